// ===== hdl/ddiff_pkg.sv =====
// ----------------------------------------------------------------------------
// ddiff_pkg
// Shared widths, constants and the month offset table for the date-time
// difference pipeline.
// ----------------------------------------------------------------------------
package ddiff_pkg;

  // Field widths of the input and result transactions
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;

  localparam int unsigned DaysW  = 22;
  localparam int unsigned HoursW = 27;
  localparam int unsigned MinsW  = 33;

  // Internal count widths (full range of a 14-bit year)
  localparam int unsigned SerialW   = 23;
  localparam int unsigned HourCntW  = 28;
  localparam int unsigned MinCntW   = 34;
  localparam int unsigned MonOffW   = 9;
  localparam int unsigned QuartW    = YearW - 2;
  localparam int unsigned CentW     = 8;
  localparam int unsigned QuadCentW = 6;

  // Reciprocal constants: x/25 = (x*1311)>>15, x/100 = (x*5243)>>19, x < 4096
  localparam int unsigned Recip25       = 1311;
  localparam int unsigned Recip25Shift  = 15;
  localparam int unsigned Recip100      = 5243;
  localparam int unsigned Recip100Shift = 19;
  localparam int unsigned Prod25W       = 24;
  localparam int unsigned Prod100W      = 25;

  localparam int unsigned DaysPerYear     = 365;
  localparam int unsigned HoursPerDay     = 24;
  localparam int unsigned MinsPerHour     = 60;
  localparam int unsigned YearsPerCentury = 100;
  localparam int unsigned MonthMarch      = 3;

  // Register stages from input to output register
  localparam int unsigned NumStages = 6;

  // Days in the months before the given one (non-leap); month zero counts
  // as January, months above twelve as December.
  function automatic logic [MonOffW-1:0] month_offset(logic [MonthW-1:0] m);
    logic [MonOffW-1:0] off;
    case (m)
      4'd0, 4'd1: off = 9'd0;
      4'd2:       off = 9'd31;
      4'd3:       off = 9'd59;
      4'd4:       off = 9'd90;
      4'd5:       off = 9'd120;
      4'd6:       off = 9'd151;
      4'd7:       off = 9'd181;
      4'd8:       off = 9'd212;
      4'd9:       off = 9'd243;
      4'd10:      off = 9'd273;
      4'd11:      off = 9'd304;
      default:    off = 9'd334;
    endcase
    return off;
  endfunction

endpackage

// ===== hdl/ddiff_in_if.sv =====
// ----------------------------------------------------------------------------
// ddiff_in_if
// Input channel: a pair of date-times with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ddiff_in_if;
  import ddiff_pkg::*;

  logic              valid;
  logic              ready;
  logic [DayW-1:0]   a_day;
  logic [MonthW-1:0] a_month;
  logic [YearW-1:0]  a_year;
  logic [HourW-1:0]  a_hour;
  logic [MinW-1:0]   a_minute;
  logic [DayW-1:0]   b_day;
  logic [MonthW-1:0] b_month;
  logic [YearW-1:0]  b_year;
  logic [HourW-1:0]  b_hour;
  logic [MinW-1:0]   b_minute;

  modport source (
    output valid, a_day, a_month, a_year, a_hour, a_minute,
    output b_day, b_month, b_year, b_hour, b_minute,
    input  ready
  );

  modport sink (
    input  valid, a_day, a_month, a_year, a_hour, a_minute,
    input  b_day, b_month, b_year, b_hour, b_minute,
    output ready
  );
endinterface

// ===== hdl/ddiff_out_if.sv =====
// ----------------------------------------------------------------------------
// ddiff_out_if
// Result channel: day, hour and minute distances plus ordering flag.
// ----------------------------------------------------------------------------
interface ddiff_out_if;
  import ddiff_pkg::*;

  logic              valid;
  logic              ready;
  logic [DaysW-1:0]  days_apart;
  logic [HoursW-1:0] hours_apart;
  logic [MinsW-1:0]  minutes_apart;
  logic              first_is_later;

  modport source (
    output valid, days_apart, hours_apart, minutes_apart, first_is_later,
    input  ready
  );

  modport sink (
    input  valid, days_apart, hours_apart, minutes_apart, first_is_later,
    output ready
  );
endinterface

// ===== hdl/ddiff_stamp.sv =====
// ----------------------------------------------------------------------------
// ddiff_stamp
// Five-stage pipeline turning one date-time into serial day (stage 3),
// hour count (stage 4) and minute count (stage 5).
// ----------------------------------------------------------------------------
module ddiff_stamp (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic [ddiff_pkg::DayW-1:0]      day_i,
  input  logic [ddiff_pkg::MonthW-1:0]    month_i,
  input  logic [ddiff_pkg::YearW-1:0]     year_i,
  input  logic [ddiff_pkg::HourW-1:0]     hour_i,
  input  logic [ddiff_pkg::MinW-1:0]      minute_i,
  output logic [ddiff_pkg::SerialW-1:0]   serial_o,
  output logic [ddiff_pkg::HourCntW-1:0]  hours_o,
  output logic [ddiff_pkg::MinCntW-1:0]   minutes_o
);
  import ddiff_pkg::*;

  // Stage 1: years before this one and their century quotients
  logic [YearW-1:0]    prior_d;
  logic [QuartW-1:0]   prior_quart;
  logic [QuartW-1:0]   year_quart;
  logic [Prod25W-1:0]  p100_prod;
  logic [Prod100W-1:0] p400_prod;
  logic [Prod25W-1:0]  y100_prod;

  logic [YearW-1:0]     year1_q, prior1_q;
  logic [CentW-1:0]     p100_1_q, y100_1_q;
  logic [QuadCentW-1:0] p400_1_q;
  logic [MonthW-1:0]    month1_q;
  logic [DayW-1:0]      day1_q;
  logic [HourW-1:0]     hour1_q;
  logic [MinW-1:0]      min1_q;

  assign prior_d     = (year_i == '0) ? '0 : year_i - YearW'(1);
  assign prior_quart = prior_d[YearW-1:2];
  assign year_quart  = year_i[YearW-1:2];
  // floor(x/100) = floor(floor(x/4)/25), floor(x/400) = floor(floor(x/4)/100)
  assign p100_prod   = Prod25W'(prior_quart) * Prod25W'(Recip25);
  assign p400_prod   = Prod100W'(prior_quart) * Prod100W'(Recip100);
  assign y100_prod   = Prod25W'(year_quart) * Prod25W'(Recip25);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      year1_q  <= year_i;
      prior1_q <= prior_d;
      p100_1_q <= p100_prod[Recip25Shift +: CentW];
      p400_1_q <= p400_prod[Recip100Shift +: QuadCentW];
      y100_1_q <= y100_prod[Recip25Shift +: CentW];
      month1_q <= month_i;
      day1_q   <= day_i;
      hour1_q  <= hour_i;
      min1_q   <= minute_i;
    end
  end

  // Stage 2: days in prior years, month offset with leap February
  logic [YearW-1:0]   cent_year;
  logic               leap;
  logic [SerialW-1:0] base_d;
  logic [MonOffW-1:0] moff_d;

  logic [SerialW-1:0] base2_q;
  logic [MonOffW-1:0] moff2_q;
  logic [DayW-1:0]    day2_q;
  logic [HourW-1:0]   hour2_q;
  logic [MinW-1:0]    min2_q;

  assign cent_year = YearW'(16'(y100_1_q) * 16'(YearsPerCentury));
  assign leap      = ((year1_q[1:0] == 2'b00) && (year1_q != cent_year)) ||
                     ((year1_q == cent_year) && (y100_1_q[1:0] == 2'b00));
  assign base_d    = SerialW'(prior1_q) * SerialW'(DaysPerYear)
                   + SerialW'(prior1_q[YearW-1:2])
                   - SerialW'(p100_1_q)
                   + SerialW'(p400_1_q);
  assign moff_d    = month_offset(month1_q)
                   + MonOffW'(leap && (month1_q >= MonthW'(MonthMarch)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      base2_q <= base_d;
      moff2_q <= moff_d;
      day2_q  <= day1_q;
      hour2_q <= hour1_q;
      min2_q  <= min1_q;
    end
  end

  // Stage 3: serial day number
  logic [SerialW-1:0] serial3_q;
  logic [HourW-1:0]   hour3_q;
  logic [MinW-1:0]    min3_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      serial3_q <= base2_q + SerialW'(moff2_q) + SerialW'(day2_q);
      hour3_q   <= hour2_q;
      min3_q    <= min2_q;
    end
  end

  // Stage 4: hour count
  logic [HourCntW-1:0] hours4_q;
  logic [MinW-1:0]     min4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hours4_q <= HourCntW'(serial3_q) * HourCntW'(HoursPerDay) + HourCntW'(hour3_q);
      min4_q   <= min3_q;
    end
  end

  // Stage 5: minute count
  logic [MinCntW-1:0] mins5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mins5_q <= MinCntW'(hours4_q) * MinCntW'(MinsPerHour) + MinCntW'(min4_q);
    end
  end

  assign serial_o  = serial3_q;
  assign hours_o   = hours4_q;
  assign minutes_o = mins5_q;

endmodule

// ===== hdl/ddiff_dist.sv =====
// ----------------------------------------------------------------------------
// ddiff_dist
// Stages 4 to 6: absolute differences with saturation, aligned to the
// result register.
// ----------------------------------------------------------------------------
module ddiff_dist (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            later_i,
  input  logic [ddiff_pkg::SerialW-1:0]   serial_a_i,
  input  logic [ddiff_pkg::SerialW-1:0]   serial_b_i,
  input  logic [ddiff_pkg::HourCntW-1:0]  hours_a_i,
  input  logic [ddiff_pkg::HourCntW-1:0]  hours_b_i,
  input  logic [ddiff_pkg::MinCntW-1:0]   mins_a_i,
  input  logic [ddiff_pkg::MinCntW-1:0]   mins_b_i,
  output logic [ddiff_pkg::DaysW-1:0]     days_o,
  output logic [ddiff_pkg::HoursW-1:0]    hours_o,
  output logic [ddiff_pkg::MinsW-1:0]     mins_o,
  output logic                            later_o
);
  import ddiff_pkg::*;

  // Stage 4: day distance
  logic [SerialW-1:0] ddays;
  logic [DaysW-1:0]   days4_q;
  logic               later4_q;

  assign ddays = (serial_a_i > serial_b_i) ? serial_a_i - serial_b_i
                                           : serial_b_i - serial_a_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days4_q  <= ddays[SerialW-1] ? '1 : ddays[DaysW-1:0];
      later4_q <= later_i;
    end
  end

  // Stage 5: hour distance
  logic [HourCntW-1:0] dhours;
  logic [DaysW-1:0]    days5_q;
  logic [HoursW-1:0]   hours5_q;
  logic                later5_q;

  assign dhours = (hours_a_i > hours_b_i) ? hours_a_i - hours_b_i
                                          : hours_b_i - hours_a_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days5_q  <= days4_q;
      hours5_q <= dhours[HourCntW-1] ? '1 : dhours[HoursW-1:0];
      later5_q <= later4_q;
    end
  end

  // Stage 6: minute distance, result register
  logic [MinCntW-1:0] dmins;
  logic [DaysW-1:0]   days6_q;
  logic [HoursW-1:0]  hours6_q;
  logic [MinsW-1:0]   mins6_q;
  logic               later6_q;

  assign dmins = (mins_a_i > mins_b_i) ? mins_a_i - mins_b_i
                                       : mins_b_i - mins_a_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      days6_q  <= days5_q;
      hours6_q <= hours5_q;
      mins6_q  <= dmins[MinCntW-1] ? '1 : dmins[MinsW-1:0];
      later6_q <= later5_q;
    end
  end

  assign days_o  = days6_q;
  assign hours_o = hours6_q;
  assign mins_o  = mins6_q;
  assign later_o = later6_q;

endmodule

// ===== hdl/datetime_difference.sv =====
// ----------------------------------------------------------------------------
// datetime_difference
// Day, hour and minute distance between two Gregorian date-times.
// ----------------------------------------------------------------------------
// Six register stages from input transaction to result register.
// Throughput: one transaction per cycle; all six stages advance together and
// hold as a whole while the result register is full and not taken.
// Reset: asynchronous, clears the stage valid bits only; no other state.
module datetime_difference (
  input  logic        clk_i,
  input  logic        rst_ni,
  ddiff_in_if.sink    in_i,
  ddiff_out_if.source out_o
);
  import ddiff_pkg::*;

  // Pipeline advance: the last stage is empty or is being drained
  logic                 en;
  logic [NumStages-1:0] valid_q;

  assign en        = !valid_q[NumStages-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= {valid_q[NumStages-2:0], in_i.valid};
    end
  end

  // Ordering flag: lexicographic compare of raw fields, carried to stage 3
  logic       later_d;
  logic [2:0] later_q;

  assign later_d = {in_i.a_year, in_i.a_month, in_i.a_day, in_i.a_hour, in_i.a_minute} >
                   {in_i.b_year, in_i.b_month, in_i.b_day, in_i.b_hour, in_i.b_minute};

  always_ff @(posedge clk_i) begin
    if (en) begin
      later_q <= {later_q[1:0], later_d};
    end
  end

  // Per date-time count pipelines
  logic [SerialW-1:0]  serial_a, serial_b;
  logic [HourCntW-1:0] hours_a, hours_b;
  logic [MinCntW-1:0]  mins_a, mins_b;

  ddiff_stamp u_stamp_a (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_i     (in_i.a_day),
    .month_i   (in_i.a_month),
    .year_i    (in_i.a_year),
    .hour_i    (in_i.a_hour),
    .minute_i  (in_i.a_minute),
    .serial_o  (serial_a),
    .hours_o   (hours_a),
    .minutes_o (mins_a)
  );

  ddiff_stamp u_stamp_b (
    .clk_i     (clk_i),
    .en_i      (en),
    .day_i     (in_i.b_day),
    .month_i   (in_i.b_month),
    .year_i    (in_i.b_year),
    .hour_i    (in_i.b_hour),
    .minute_i  (in_i.b_minute),
    .serial_o  (serial_b),
    .hours_o   (hours_b),
    .minutes_o (mins_b)
  );

  // Distances and result register
  ddiff_dist u_dist (
    .clk_i      (clk_i),
    .en_i       (en),
    .later_i    (later_q[2]),
    .serial_a_i (serial_a),
    .serial_b_i (serial_b),
    .hours_a_i  (hours_a),
    .hours_b_i  (hours_b),
    .mins_a_i   (mins_a),
    .mins_b_i   (mins_b),
    .days_o     (out_o.days_apart),
    .hours_o    (out_o.hours_apart),
    .mins_o     (out_o.minutes_apart),
    .later_o    (out_o.first_is_later)
  );

  assign out_o.valid = valid_q[NumStages-1];

  // Same serial day leaves only the hour fields apart
  a_same_day_hours : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.days_apart == '0)) |-> (out_o.hours_apart < HoursW'(32)))
    else $error("hour distance too large for equal day numbers");

  // Same hour count leaves only the minute fields apart
  a_same_hour_mins : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.hours_apart == '0)) |-> (out_o.minutes_apart < MinsW'(64)))
    else $error("minute distance too large for equal hour counts");

  // Input is held back only by a full, untaken result register
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (valid_q[NumStages-1] && !out_o.ready))
    else $error("input stalled without a pending result");

  // A stalled pipeline keeps its occupancy
  a_stall_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("stage valid bits changed during a stall");

endmodule
